/* hdl/lvsp_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lvsp_pkg
// shared types, field positions and reset values for the lead vehicle and
// stop point scan block
// ----------------------------------------------------------------------------
package lvsp_pkg;

    localparam int QUEUE_DEPTH = 4;

    // field widths
    localparam int POS_W   = 19;
    localparam int SPD_W   = 18;
    localparam int LEN_W   = 15;
    localparam int ID_W    = 16;
    localparam int EGO_W   = 17;
    localparam int STOP_W  = 17;
    localparam int OUTV_W  = 18;

    // slave tdata layout
    localparam int IN_X_LSB    = 0;
    localparam int IN_Y_LSB    = IN_X_LSB + POS_W;
    localparam int IN_SPD_LSB  = IN_Y_LSB + POS_W;
    localparam int IN_LEN_LSB  = IN_SPD_LSB + SPD_W;
    localparam int IN_ID_LSB   = IN_LEN_LSB + LEN_W;
    localparam int IN_EGO_LSB  = IN_ID_LSB + ID_W;
    localparam int IN_DATA_W   = 104;

    // master tdata layout
    localparam int OUT_FF_BIT   = 0;
    localparam int OUT_FS_LSB   = 1;
    localparam int OUT_ID_LSB   = OUT_FS_LSB + OUTV_W;
    localparam int OUT_SF_BIT   = OUT_ID_LSB + ID_W;
    localparam int OUT_SP_LSB   = OUT_SF_BIT + 1;
    localparam int OUT_DATA_W   = 56;

    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    localparam logic [OUTV_W-1:0] SPEED_CAP = 18'd200000;

    // register reset values
    localparam logic [13:0] LAT_LIMIT_RST  = 14'd1750;
    localparam logic [13:0] STATIC_SPD_RST = 14'd500;
    localparam logic [14:0] STANDOFF_RST   = 15'd2500;
    localparam logic [15:0] MIN_GAP_RST    = 16'd5000;
    localparam logic [12:0] HEADWAY_RST    = 13'd1536;
    localparam logic [10:0] GAIN_RST       = 11'd77;
    localparam logic [16:0] STOP_DIST_RST  = 17'd20000;

    typedef enum logic [2:0] {
        REG_LAT_LIMIT  = 3'd0,
        REG_STATIC_SPD = 3'd1,
        REG_STANDOFF   = 3'd2,
        REG_MIN_GAP    = 3'd3,
        REG_HEADWAY    = 3'd4,
        REG_GAIN       = 3'd5,
        REG_STOP_DIST  = 3'd6
    } reg_index_t;

    typedef struct packed {
        logic [13:0] lat_limit;
        logic [13:0] static_spd;
        logic [14:0] standoff;
        logic [15:0] min_gap;
        logic [12:0] headway;
        logic [10:0] gain;
        logic [16:0] stop_dist;
    } cfg_t;

    // classified obstacle as it travels from front to back
    typedef struct packed {
        logic                     lead_cand;
        logic                     stop_cand;
        logic                     last;
        logic signed [POS_W-1:0]  x;
        logic signed [SPD_W-1:0]  spd;
        logic [LEN_W-1:0]         len;
        logic [ID_W-1:0]          id;
        logic [STOP_W-1:0]        stop_s;
        logic [EGO_W-1:0]         ego;
    } item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef enum logic [2:0] {
        BK_SCAN,
        BK_GAP,
        BK_DIFF,
        BK_MUL,
        BK_EMIT
    } back_state_t;

endpackage
`default_nettype wire

/* hdl/lvsp_regs.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lvsp_regs
// apb register file holding the scan and follow-speed settings
// ----------------------------------------------------------------------------
module lvsp_regs
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [lvsp_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [lvsp_pkg::APB_DATA_W-1:0]    pwdata,
    output logic      [lvsp_pkg::APB_DATA_W-1:0]    prdata,
    output lvsp_pkg::cfg_t                          cfg
);

    lvsp_pkg::cfg_t       cfg_reg;
    lvsp_pkg::cfg_t       cfg_next;
    lvsp_pkg::reg_index_t idx;
    logic                 wr_en;

    assign idx   = lvsp_pkg::reg_index_t'(paddr[4:2]);
    assign wr_en = psel && penable && pwrite;
    assign cfg   = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                lvsp_pkg::REG_LAT_LIMIT:  cfg_next.lat_limit  = pwdata[13:0];
                lvsp_pkg::REG_STATIC_SPD: cfg_next.static_spd = pwdata[13:0];
                lvsp_pkg::REG_STANDOFF:   cfg_next.standoff   = pwdata[14:0];
                lvsp_pkg::REG_MIN_GAP:    cfg_next.min_gap    = pwdata[15:0];
                lvsp_pkg::REG_HEADWAY:    cfg_next.headway    = pwdata[12:0];
                lvsp_pkg::REG_GAIN:       cfg_next.gain       = pwdata[10:0];
                lvsp_pkg::REG_STOP_DIST:  cfg_next.stop_dist  = pwdata[16:0];
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            lvsp_pkg::REG_LAT_LIMIT:  prdata = {18'd0, cfg_reg.lat_limit};
            lvsp_pkg::REG_STATIC_SPD: prdata = {18'd0, cfg_reg.static_spd};
            lvsp_pkg::REG_STANDOFF:   prdata = {17'd0, cfg_reg.standoff};
            lvsp_pkg::REG_MIN_GAP:    prdata = {16'd0, cfg_reg.min_gap};
            lvsp_pkg::REG_HEADWAY:    prdata = {19'd0, cfg_reg.headway};
            lvsp_pkg::REG_GAIN:       prdata = {21'd0, cfg_reg.gain};
            lvsp_pkg::REG_STOP_DIST:  prdata = {15'd0, cfg_reg.stop_dist};
            default:                  prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lat_limit  <= lvsp_pkg::LAT_LIMIT_RST;
            cfg_reg.static_spd <= lvsp_pkg::STATIC_SPD_RST;
            cfg_reg.standoff   <= lvsp_pkg::STANDOFF_RST;
            cfg_reg.min_gap    <= lvsp_pkg::MIN_GAP_RST;
            cfg_reg.headway    <= lvsp_pkg::HEADWAY_RST;
            cfg_reg.gain       <= lvsp_pkg::GAIN_RST;
            cfg_reg.stop_dist  <= lvsp_pkg::STOP_DIST_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule
`default_nettype wire

/* hdl/lvsp_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lvsp_front
// takes obstacle beats, applies the lane gate and marks each obstacle as
// lead candidate, stop candidate or neither, one registered stage
// ----------------------------------------------------------------------------
module lvsp_front
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire lvsp_pkg::cfg_t                     cfg,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  wire logic [lvsp_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    input  wire logic [0:0]                         s_axis_tuser,
    input  wire logic                               s_axis_tlast,
    input  wire lvsp_pkg::q_stat_t                  qstat,
    output logic                                    push,
    output lvsp_pkg::item_t                         push_item
);

    localparam int PW = lvsp_pkg::POS_W;
    localparam int SW = lvsp_pkg::SPD_W;
    localparam int LW = lvsp_pkg::LEN_W;

    logic signed [PW-1:0]   x;
    logic        [PW-1:0]   y_u;
    logic        [PW-1:0]   ay;
    logic signed [SW-1:0]   spd;
    logic        [LW-1:0]   len;
    logic signed [PW:0]     s;
    logic                   in_lane;
    logic                   moving;
    logic                   s_ok;
    logic                   accept;
    lvsp_pkg::item_t        item;
    lvsp_pkg::item_t        item_reg;
    logic                   valid_reg;
    logic                   valid_next;

    assign x   = s_axis_tdata[lvsp_pkg::IN_X_LSB +: PW];
    assign y_u = s_axis_tdata[lvsp_pkg::IN_Y_LSB +: PW];
    assign spd = s_axis_tdata[lvsp_pkg::IN_SPD_LSB +: SW];
    assign len = s_axis_tdata[lvsp_pkg::IN_LEN_LSB +: LW];
    assign ay  = y_u[PW-1] ? (~y_u + {{(PW-1){1'b0}}, 1'b1}) : y_u;

    assign in_lane = (x > $signed({PW{1'b0}}))
                  && (ay <= {5'd0, cfg.lat_limit});
    assign moving  = $signed({spd[SW-1], spd}) >= $signed({5'd0, cfg.static_spd});
    assign s       = $signed({x[PW-1], x}) - $signed({5'd0, cfg.standoff})
                   - $signed({6'd0, len[LW-1:1]});
    assign s_ok    = s <= $signed({3'd0, cfg.stop_dist});

    always_comb
    begin
        item.lead_cand = s_axis_tuser[0] && in_lane && moving;
        item.stop_cand = s_axis_tuser[0] && in_lane && !moving && s_ok;
        item.last      = s_axis_tlast;
        item.x         = x;
        item.spd       = spd;
        item.len       = len;
        item.id        = s_axis_tdata[lvsp_pkg::IN_ID_LSB +: lvsp_pkg::ID_W];
        item.stop_s    = s[PW] ? '0 : s[lvsp_pkg::STOP_W-1:0];
        item.ego       = s_axis_tdata[lvsp_pkg::IN_EGO_LSB +: lvsp_pkg::EGO_W];
    end

    assign s_axis_tready = !valid_reg || !qstat.full;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign push          = valid_reg && !qstat.full;
    assign push_item     = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (push)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item;
        end
    end

endmodule
`default_nettype wire

/* hdl/lvsp_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lvsp_queue
// short first-in first-out queue of classified obstacles between front
// and back
// ----------------------------------------------------------------------------
module lvsp_queue
#(
    parameter int DEPTH = lvsp_pkg::QUEUE_DEPTH
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire lvsp_pkg::item_t    push_item,
    input  wire logic               pop,
    output lvsp_pkg::item_t         head,
    output lvsp_pkg::q_stat_t       qstat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    lvsp_pkg::item_t    mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    assign qstat.full  = count_reg == CNT_FULL;
    assign qstat.empty = count_reg == '0;
    assign head        = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule
`default_nettype wire

/* hdl/lvsp_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lvsp_back
// keeps the nearest lead and stop point of the frame and, at frame end,
// works out the constant time gap speed and holds the result beat
// ----------------------------------------------------------------------------
module lvsp_back
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire lvsp_pkg::cfg_t                     cfg,
    input  wire lvsp_pkg::q_stat_t                  qstat,
    input  wire lvsp_pkg::item_t                    head,
    output logic                                    pop,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    output logic [lvsp_pkg::OUT_DATA_W-1:0]         m_axis_tdata
);

    localparam int PW = lvsp_pkg::POS_W;
    localparam int SW = lvsp_pkg::SPD_W;
    localparam int VW = lvsp_pkg::OUTV_W;

    lvsp_pkg::back_state_t  state_reg;
    lvsp_pkg::back_state_t  state_next;
    logic                   load;

    logic                   lead_valid_reg;
    logic signed [PW-1:0]   lead_ahead_reg;
    logic signed [SW-1:0]   lead_speed_reg;
    logic [lvsp_pkg::LEN_W-1:0] lead_len_reg;
    logic [lvsp_pkg::ID_W-1:0]  lead_tag_reg;
    logic                   stop_valid_reg;
    logic [lvsp_pkg::STOP_W-1:0] stop_best_reg;
    logic [lvsp_pkg::EGO_W-1:0]  ego_reg;

    logic [29:0]            hw_prod_reg;
    logic signed [19:0]     gap_reg;
    logic signed [21:0]     diff_reg;
    logic signed [33:0]     gprod_reg;
    logic [20:0]            desired;
    logic signed [26:0]     v;
    logic [VW-1:0]          v_sat;
    logic                   take_lead;
    logic                   take_stop;

    logic                   out_valid_reg;
    logic [lvsp_pkg::OUT_DATA_W-1:0] out_data_reg;
    logic [lvsp_pkg::OUT_DATA_W-1:0] out_data_next;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lvsp_pkg::BK_SCAN:
            begin
                if (!qstat.empty && head.last)
                begin
                    state_next = lvsp_pkg::BK_GAP;
                end
            end
            lvsp_pkg::BK_GAP:  state_next = lvsp_pkg::BK_DIFF;
            lvsp_pkg::BK_DIFF: state_next = lvsp_pkg::BK_MUL;
            lvsp_pkg::BK_MUL:  state_next = lvsp_pkg::BK_EMIT;
            lvsp_pkg::BK_EMIT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    state_next = lvsp_pkg::BK_SCAN;
                end
            end
            default: state_next = lvsp_pkg::BK_SCAN;
        endcase
    end

    // state outputs
    always_comb
    begin
        pop  = 1'b0;
        load = 1'b0;
        unique case (state_reg)
            lvsp_pkg::BK_SCAN: pop  = !qstat.empty;
            lvsp_pkg::BK_EMIT: load = !out_valid_reg || m_axis_tready;
            default:
            begin
                pop  = 1'b0;
                load = 1'b0;
            end
        endcase
    end

    assign take_lead = pop && head.lead_cand
                    && (!lead_valid_reg || (head.x < lead_ahead_reg));
    assign take_stop = pop && head.stop_cand
                    && (!stop_valid_reg || (head.stop_s < stop_best_reg));

    assign desired = {5'd0, cfg.min_gap} + {1'b0, hw_prod_reg[29:10]};
    assign v       = $signed({{9{lead_speed_reg[SW-1]}}, lead_speed_reg})
                   + $signed({gprod_reg[33], gprod_reg[33:8]});

    always_comb
    begin
        if (v < 0)
        begin
            v_sat = '0;
        end
        else if (v > $signed({9'd0, lvsp_pkg::SPEED_CAP}))
        begin
            v_sat = lvsp_pkg::SPEED_CAP;
        end
        else
        begin
            v_sat = v[VW-1:0];
        end
    end

    always_comb
    begin
        out_data_next = '0;
        out_data_next[lvsp_pkg::OUT_FF_BIT] = lead_valid_reg;
        out_data_next[lvsp_pkg::OUT_FS_LSB +: VW] = lead_valid_reg ? v_sat : '0;
        out_data_next[lvsp_pkg::OUT_ID_LSB +: lvsp_pkg::ID_W] =
            lead_valid_reg ? lead_tag_reg : '0;
        out_data_next[lvsp_pkg::OUT_SF_BIT] = stop_valid_reg;
        out_data_next[lvsp_pkg::OUT_SP_LSB +: VW] =
            stop_valid_reg ? {1'b0, stop_best_reg} : '0;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= lvsp_pkg::BK_SCAN;
            lead_valid_reg <= 1'b0;
            stop_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load)
            begin
                lead_valid_reg <= 1'b0;
                stop_valid_reg <= 1'b0;
            end
            else
            begin
                if (take_lead)
                begin
                    lead_valid_reg <= 1'b1;
                end
                if (take_stop)
                begin
                    stop_valid_reg <= 1'b1;
                end
            end
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_lead)
        begin
            lead_ahead_reg <= head.x;
            lead_speed_reg <= head.spd;
            lead_len_reg   <= head.len;
            lead_tag_reg   <= head.id;
        end
        if (take_stop)
        begin
            stop_best_reg <= head.stop_s;
        end
        if (pop && head.last)
        begin
            ego_reg <= head.ego;
        end
        if (state_reg == lvsp_pkg::BK_GAP)
        begin
            hw_prod_reg <= cfg.headway * ego_reg;
            gap_reg     <= $signed({lead_ahead_reg[PW-1], lead_ahead_reg})
                         - $signed({5'd0, cfg.standoff})
                         - $signed({6'd0, lead_len_reg[lvsp_pkg::LEN_W-1:1]});
        end
        if (state_reg == lvsp_pkg::BK_DIFF)
        begin
            diff_reg <= $signed({{2{gap_reg[19]}}, gap_reg}) - $signed({1'b0, desired});
        end
        if (state_reg == lvsp_pkg::BK_MUL)
        begin
            gprod_reg <= $signed({1'b0, cfg.gain}) * diff_reg;
        end
        if (load)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule
`default_nettype wire

/* hdl/lead_vehicle_and_stop_point_scan_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lead_vehicle_and_stop_point_scan_core
// scans a frame of obstacles for the nearest moving lead and the nearest
// static stop point, and emits a constant time gap target speed per frame
//
// channel   direction  beat contents
// s_axis    in         one obstacle; tuser = present, tlast = frame end
// m_axis    out        one frame result after the frame end beat
// apb       in/out     seven settings registers at 4*index
//
// the front takes one beat per cycle while the queue has room; the back drains
// one queued beat per cycle while it scans; a frame end beat runs the back
// through gap and headway product, gap error, gain product and saturate in turn
// a held result beat parks the back; the front fills the queue, then stalls
// reset clears all control state at once; there is no clearing pass
// ----------------------------------------------------------------------------
module lead_vehicle_and_stop_point_scan_core
#(
    parameter int QUEUE_DEPTH = lvsp_pkg::QUEUE_DEPTH
)
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // pos_ahead, pos_side, obs_speed, obs_length, obs_id, ego_speed
    input  wire logic [lvsp_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // present
    input  wire logic [0:0]                         s_axis_tuser,
    input  wire logic                               s_axis_tlast,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // follow_found, follow_speed, lead_ident, stop_found, stop_position
    output logic [lvsp_pkg::OUT_DATA_W-1:0]         m_axis_tdata,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [lvsp_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [lvsp_pkg::APB_DATA_W-1:0]    pwdata,
    output logic      [lvsp_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                    pready
);

    lvsp_pkg::cfg_t     cfg;
    lvsp_pkg::q_stat_t  qstat;
    lvsp_pkg::item_t    push_item;
    lvsp_pkg::item_t    head;
    logic               push;
    logic               pop;

    assign pready = 1'b1;

    lvsp_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    lvsp_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .qstat         (qstat),
        .push          (push),
        .push_item     (push_item)
    );

    lvsp_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .qstat     (qstat)
    );

    lvsp_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .qstat         (qstat),
        .head          (head),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

`ifndef ASSERT_OFF
    a_no_lead_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[34:1] == 34'd0)
        else $error("follow fields set without a lead");

    a_speed_cap: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[18:1] <= lvsp_pkg::SPEED_CAP)
        else $error("follow speed above cap");

    a_no_stop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[35] |-> m_axis_tdata[53:36] == 18'd0)
        else $error("stop position set without a stop point");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> qstat.full)
        else $error("input stalled while queue has room");
`endif

endmodule
`default_nettype wire

/* verif/lvsp_tb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lvsp_tb_pkg
// obstacle and frame result types for the scan core bench, and a checker
// class that keeps its own lead and stop point state per frame, predicts the
// result of every frame end beat and compares it with what the core emits
// ----------------------------------------------------------------------------
package lvsp_tb_pkg;

    import lvsp_pkg::*;

    typedef struct packed {
        logic                    present;
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [SPD_W-1:0] spd;
        logic [LEN_W-1:0]        len;
        logic [ID_W-1:0]         id;
        logic [EGO_W-1:0]        ego;
        logic                    last;
    } obstacle_t;

    typedef struct packed {
        logic              follow_found;
        logic [OUTV_W-1:0] follow_speed;
        logic [ID_W-1:0]   lead_ident;
        logic              stop_found;
        logic [OUTV_W-1:0] stop_position;
    } frame_result_t;

    class frame_result_checker;

        cfg_t            cfg;
        logic            lead_valid;
        longint          lead_x;
        longint          lead_spd;
        longint          lead_len;
        logic [ID_W-1:0] lead_id;
        logic            stop_valid;
        longint          stop_best;
        frame_result_t   expected_frames[$];
        int              errors;
        int              beats;
        int              frames;
        int              leads;
        int              stops;

        function new();
            cfg.lat_limit  = LAT_LIMIT_RST;
            cfg.static_spd = STATIC_SPD_RST;
            cfg.standoff   = STANDOFF_RST;
            cfg.min_gap    = MIN_GAP_RST;
            cfg.headway    = HEADWAY_RST;
            cfg.gain       = GAIN_RST;
            cfg.stop_dist  = STOP_DIST_RST;
            errors = 0;
            beats  = 0;
            frames = 0;
            leads  = 0;
            stops  = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            lead_valid = 1'b0;
            lead_x     = 0;
            lead_spd   = 0;
            lead_len   = 0;
            lead_id    = '0;
            stop_valid = 1'b0;
            stop_best  = 0;
        endfunction

        // returns the value a read of the register gives back
        function logic [31:0] set_register(reg_index_t idx, logic [31:0] value);
            case (idx)
                REG_LAT_LIMIT:
                begin
                    cfg.lat_limit = value[13:0];
                    return 32'(cfg.lat_limit);
                end
                REG_STATIC_SPD:
                begin
                    cfg.static_spd = value[13:0];
                    return 32'(cfg.static_spd);
                end
                REG_STANDOFF:
                begin
                    cfg.standoff = value[14:0];
                    return 32'(cfg.standoff);
                end
                REG_MIN_GAP:
                begin
                    cfg.min_gap = value[15:0];
                    return 32'(cfg.min_gap);
                end
                REG_HEADWAY:
                begin
                    cfg.headway = value[12:0];
                    return 32'(cfg.headway);
                end
                REG_GAIN:
                begin
                    cfg.gain = value[10:0];
                    return 32'(cfg.gain);
                end
                REG_STOP_DIST:
                begin
                    cfg.stop_dist = value[16:0];
                    return 32'(cfg.stop_dist);
                end
                default:        return 32'd0;
            endcase
        endfunction

        function int pending();
            return expected_frames.size();
        endfunction

        function void note_obstacle(obstacle_t b);
            longint        xv;
            longint        yv;
            longint        sv;
            longint        s;
            longint        gap;
            longint        desired;
            longint        v;
            frame_result_t r;
            beats++;
            xv = $signed(b.x);
            yv = $signed(b.y);
            sv = $signed(b.spd);
            if (yv < 0)
                yv = -yv;
            if (b.present && xv > 0 && yv <= longint'(cfg.lat_limit))
            begin
                if (sv >= longint'(cfg.static_spd))
                begin
                    if (!lead_valid || xv < lead_x)
                    begin
                        lead_valid = 1'b1;
                        lead_x     = xv;
                        lead_spd   = sv;
                        lead_len   = longint'(b.len);
                        lead_id    = b.id;
                    end
                end
                else
                begin
                    s = xv - longint'(cfg.standoff) - longint'(b.len >> 1);
                    if (s <= longint'(cfg.stop_dist))
                    begin
                        if (s < 0)
                            s = 0;
                        if (!stop_valid || s < stop_best)
                        begin
                            stop_valid = 1'b1;
                            stop_best  = s;
                        end
                    end
                end
            end
            if (!b.last)
                return;
            r = '0;
            if (lead_valid)
            begin
                gap     = lead_x - longint'(cfg.standoff) - (lead_len >>> 1);
                desired = longint'(cfg.min_gap)
                        + ((longint'(cfg.headway) * longint'(b.ego)) >>> 10);
                v = lead_spd + ((longint'(cfg.gain) * (gap - desired)) >>> 8);
                if (v < 0)
                    v = 0;
                if (v > longint'(SPEED_CAP))
                    v = longint'(SPEED_CAP);
                r.follow_found = 1'b1;
                r.follow_speed = OUTV_W'(v);
                r.lead_ident   = lead_id;
                leads++;
            end
            if (stop_valid)
            begin
                r.stop_found    = 1'b1;
                r.stop_position = OUTV_W'(stop_best);
                stops++;
            end
            expected_frames.insert(expected_frames.size(), r);
            clear_frame();
        endfunction

        function void compare_field(string field, longint want, longint got);
            if (want != got)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            end
        endfunction

        function void check_frame_result(logic [OUT_DATA_W-1:0] d);
            frame_result_t want;
            if (expected_frames.size() == 0)
            begin
                errors++;
                $display("%0t: result beat with nothing expected, actual %h", $time, d);
                return;
            end
            want = expected_frames.pop_front();
            frames++;
            compare_field("follow_found", want.follow_found, d[OUT_FF_BIT]);
            compare_field("follow_speed", want.follow_speed, d[OUT_FS_LSB +: OUTV_W]);
            compare_field("lead_ident", want.lead_ident, d[OUT_ID_LSB +: ID_W]);
            compare_field("stop_found", want.stop_found, d[OUT_SF_BIT]);
            compare_field("stop_position", want.stop_position, d[OUT_SP_LSB +: OUTV_W]);
        endfunction

    endclass

endpackage

/* verif/lead_vehicle_and_stop_point_scan_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lead_vehicle_and_stop_point_scan_core_tb
// drives obstacle frames through the scan core under several register
// settings, with bursty input and a stalling result side, and checks every
// frame result against a predicted lead speed and stop point
// ----------------------------------------------------------------------------
module lead_vehicle_and_stop_point_scan_core_tb;

    import lvsp_pkg::*;
    import lvsp_tb_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_WAIT   = 24;
    localparam int PHASES       = 8;
    localparam int PHASE_BEATS  = 1700 / PHASES;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [0:0]            s_axis_tuser = '0;
    logic                  s_axis_tlast = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    frame_result_checker   sb;
    int unsigned           cycle_count = 0;
    int                    stall_mode = 0;
    int                    stall_left = 0;
    int                    burst_left = 0;
    int                    phase_beats = 0;
    logic signed [POS_W-1:0] prev_x = '0;

    lead_vehicle_and_stop_point_scan_core DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("%0t: timed out with %0d frame results outstanding", $time, sb.pending());
            $display("lead_vehicle_and_stop_point_scan_core_tb: done, errors");
            $finish;
        end
    end

    // result side stall pattern: free running, random, sparse or periodic
    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (stall_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                stall_left = $urandom_range(16, 96);
            end
            else
                stall_left--;
            case (stall_mode)
                0:       m_axis_tready <= 1'b1;
                1:       m_axis_tready <= 1'($urandom_range(0, 1));
                2:       m_axis_tready <= ($urandom_range(0, 4) == 0);
                default: m_axis_tready <= (cycle_count[2:0] != 3'd0);
            endcase
        end
    end

    function automatic obstacle_t unpack_beat(logic [IN_DATA_W-1:0] d, logic present,
                                              logic last);
        obstacle_t b;
        b.present = present;
        b.x       = d[IN_X_LSB +: POS_W];
        b.y       = d[IN_Y_LSB +: POS_W];
        b.spd     = d[IN_SPD_LSB +: SPD_W];
        b.len     = d[IN_LEN_LSB +: LEN_W];
        b.id      = d[IN_ID_LSB +: ID_W];
        b.ego     = d[IN_EGO_LSB +: EGO_W];
        b.last    = last;
        return b;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
            sb.note_obstacle(unpack_beat(s_axis_tdata, s_axis_tuser[0], s_axis_tlast));
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_frame_result(m_axis_tdata);
    end

    function automatic obstacle_t obstacle(logic present, int x, int y, int spd, int len,
                                           int id, int ego, logic last);
        obstacle_t b;
        b.present = present;
        b.x       = x[POS_W-1:0];
        b.y       = y[POS_W-1:0];
        b.spd     = spd[SPD_W-1:0];
        b.len     = len[LEN_W-1:0];
        b.id      = id[ID_W-1:0];
        b.ego     = ego[EGO_W-1:0];
        b.last    = last;
        return b;
    endfunction

    task automatic pace();
        int gap;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic send_obstacle(obstacle_t b);
        logic [IN_DATA_W-1:0] d;
        pace();
        d = '0;
        d[IN_X_LSB +: POS_W]    = b.x;
        d[IN_Y_LSB +: POS_W]    = b.y;
        d[IN_SPD_LSB +: SPD_W]  = b.spd;
        d[IN_LEN_LSB +: LEN_W]  = b.len;
        d[IN_ID_LSB +: ID_W]    = b.id;
        d[IN_EGO_LSB +: EGO_W]  = b.ego;
        s_axis_tdata  <= d;
        s_axis_tuser  <= b.present;
        s_axis_tlast  <= b.last;
        s_axis_tvalid <= 1'b1;
        do @(posedge clk); while (!s_axis_tready);
        phase_beats++;
    endtask

    function automatic obstacle_t random_obstacle();
        obstacle_t    b;
        logic [127:0] raw;
        int           reach;
        int           g;
        int           thr;
        int           xv;
        int           yv;
        int           sv;
        if ($urandom_range(0, 15) == 0)
        begin
            raw = {$urandom(), $urandom(), $urandom(), $urandom()};
            b = raw[$bits(obstacle_t)-1:0];
            return b;
        end
        reach = int'(sb.cfg.stop_dist) + int'(sb.cfg.standoff) + 40000;
        g     = int'(sb.cfg.lat_limit);
        thr   = int'(sb.cfg.static_spd);
        xv    = int'($urandom_range(0, reach)) - 2000;
        if ($urandom_range(0, 7) == 0)
            xv = prev_x;
        yv = int'($urandom_range(0, 2 * g + 600)) - (g + 300);
        case ($urandom_range(0, 4))
            0:       sv = thr;
            1:       sv = thr - 1 - int'($urandom_range(0, 3000));
            2:       sv = thr - 1 - int'($urandom_range(0, 100000));
            default: sv = thr + int'($urandom_range(0, 30000));
        endcase
        b = obstacle($urandom_range(0, 9) != 0, xv, yv, sv, $urandom_range(0, 20000),
                     $urandom_range(0, 65535),
                     ($urandom_range(0, 7) == 0) ? $urandom_range(0, 131071)
                                                 : $urandom_range(0, 100000),
                     1'b0);
        prev_x = b.x;
        return b;
    endfunction

    task automatic random_frame();
        obstacle_t b;
        int        n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
        for (int i = 0; i < n; i++)
        begin
            b = random_obstacle();
            if (i == n - 1)
                b.last = 1'b1;
            send_obstacle(b);
        end
    endtask

    task automatic apb_xfer(logic wr, reg_index_t idx, logic [31:0] wdata,
                            output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rdata = prdata;
    endtask

    task automatic write_register(reg_index_t idx, logic [31:0] value);
        logic [31:0] rd;
        logic [31:0] want;
        apb_xfer(1'b1, idx, value, rd);
        want = sb.set_register(idx, value);
        apb_xfer(1'b0, idx, 32'd0, rd);
        if (rd !== want)
        begin
            sb.errors++;
            $display("%0t: %s readback mismatch, expected %0d, actual %0d",
                     $time, idx.name(), want, rd);
        end
    endtask

    task automatic apply_settings(cfg_t c);
        write_register(REG_LAT_LIMIT, 32'(c.lat_limit));
        write_register(REG_STATIC_SPD, 32'(c.static_spd));
        write_register(REG_STANDOFF, 32'(c.standoff));
        write_register(REG_MIN_GAP, 32'(c.min_gap));
        write_register(REG_HEADWAY, 32'(c.headway));
        write_register(REG_GAIN, 32'(c.gain));
        write_register(REG_STOP_DIST, 32'(c.stop_dist));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain_frames();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // reset settings: gate 1750, static below 500, standoff 2500, stop range 20000
    task automatic directed_frames();
        send_obstacle(obstacle(0, 0, 0, 0, 0, 0, 0, 1));
        send_obstacle(obstacle(0, -262144, 262143, -131072, 32767, 65535, 131071, 1));
        // equal positions keep the first lead, empty beat ignored, stop clamps at zero
        send_obstacle(obstacle(1, 30000, 0, 500, 4000, 1, 0, 0));
        send_obstacle(obstacle(1, 30000, 0, 9000, 0, 2, 0, 0));
        send_obstacle(obstacle(1, 40000, -100, 20000, 0, 3, 0, 0));
        send_obstacle(obstacle(0, 1000, 0, 600, 0, 4, 0, 0));
        send_obstacle(obstacle(1, 1000, 0, 0, 20000, 5, 131071, 1));
        // lane gate edges, not ahead, stop exactly at range and just beyond
        send_obstacle(obstacle(1, 50000, 1750, 500, 0, 10, 0, 0));
        send_obstacle(obstacle(1, 10, -1751, 800, 0, 11, 0, 0));
        send_obstacle(obstacle(1, 0, 0, 800, 0, 12, 0, 0));
        send_obstacle(obstacle(1, -262144, 0, 800, 0, 13, 0, 0));
        send_obstacle(obstacle(1, 22500, -1750, 499, 0, 14, 0, 0));
        send_obstacle(obstacle(1, 22501, 0, 499, 0, 15, 0, 0));
        send_obstacle(obstacle(1, 262143, -262144, -131072, 32767, 65535, 0, 1));
        // speed saturates high, then low
        send_obstacle(obstacle(1, 262143, 0, 131071, 0, 65535, 0, 1));
        send_obstacle(obstacle(1, 1, -1750, -131072, 0, 20, 0, 0));
        send_obstacle(obstacle(1, 1, 1, 500, 32767, 21, 131071, 1));
        // nearest of several stop points, no lead
        send_obstacle(obstacle(1, 15000, 0, 0, 2000, 30, 0, 0));
        send_obstacle(obstacle(1, 9000, 0, -50, 1001, 31, 0, 0));
        send_obstacle(obstacle(1, 12000, 0, 100, 0, 32, 50000, 1));
    endtask

    function automatic cfg_t phase_settings(int p);
        cfg_t c;
        case (p)
            1: c = '{10000, 10000, 20000, 50000, 5120, 1024, 100000};
            2: c = '0;
            3: c = '1;
            7: c = '{LAT_LIMIT_RST, STATIC_SPD_RST, STANDOFF_RST, MIN_GAP_RST,
                     HEADWAY_RST, GAIN_RST, STOP_DIST_RST};
            default:
            begin
                c.lat_limit  = 14'($urandom_range(0, 10000));
                c.static_spd = 14'($urandom_range(0, 10000));
                c.standoff   = 15'($urandom_range(0, 20000));
                c.min_gap    = 16'($urandom_range(0, 50000));
                c.headway    = 13'($urandom_range(0, 5120));
                c.gain       = 11'($urandom_range(0, 1024));
                c.stop_dist  = 17'($urandom_range(0, 100000));
            end
        endcase
        return c;
    endfunction

    initial
    begin
        sb = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int p = 0; p < PHASES; p++)
        begin
            phase_beats = 0;
            if (p == 0)
                directed_frames();
            else
                apply_settings(phase_settings(p));
            while (phase_beats < PHASE_BEATS)
                random_frame();
            drain_frames();
        end
        $display("%0d obstacle beats over %0d register settings, %0d frames checked",
                 sb.beats, PHASES, sb.frames);
        $display("%0d frames with a lead, %0d with a stop point", sb.leads, sb.stops);
        if (sb.errors == 0)
            $display("lead_vehicle_and_stop_point_scan_core_tb: done, clean");
        else
            $display("lead_vehicle_and_stop_point_scan_core_tb: done, errors");
        $finish;
    end

endmodule

/* sim.f */
hdl/lvsp_pkg.sv
hdl/lvsp_regs.sv
hdl/lvsp_front.sv
hdl/lvsp_queue.sv
hdl/lvsp_back.sv
hdl/lead_vehicle_and_stop_point_scan_core.sv
verif/lvsp_tb_pkg.sv
verif/lead_vehicle_and_stop_point_scan_core_tb.sv
